// ===== rtl/array_linked_list_with_free_list_core_assert.svh =====
// assertion macros for the linked list core
`ifndef ARRAY_LINKED_LIST_WITH_FREE_LIST_CORE_ASSERT_SVH
`define ARRAY_LINKED_LIST_WITH_FREE_LIST_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ALFL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ALFL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/alfl_pkg.sv =====
package alfl_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned PTR_W    = $clog2(CAPACITY + 1);

  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned COUNT_W  = 5;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [IDX_W-1:0] idx_t;

  // null link and the full-count mark share the value CAPACITY
  localparam ptr_t NIL     = ptr_t'(CAPACITY);
  localparam ptr_t CAP_CNT = ptr_t'(CAPACITY);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    ptr_t next;
    ptr_t prev;
  } link_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [KIND_W-1:0]   kind;
  } pay_t;

  typedef struct packed {
    logic  re;
    idx_t  raddr;
    logic  we;
    idx_t  waddr;
    link_t wdata;
    link_t wmask;
  } link_req_t;

  typedef struct packed {
    logic re;
    idx_t raddr;
    logic we;
    idx_t waddr;
    pay_t wdata;
  } pay_req_t;

  typedef struct packed {
    ptr_t count;
    logic head_nil;
    logic tail_nil;
    logic busy;
  } stat_t;

endpackage

// ===== rtl/array_linked_list_with_free_list_core.sv =====
// Doubly linked list of up to CAPACITY entries (key, handle, kind) kept in two
// RAMs with registered reads, one for the payload and one for next/prev links,
// with a free-slot chain. One beat in gives one beat out. An insert writes the
// new slot's links and payload, then on a non-empty list links the old tail to
// it. Lookups and deletes walk from the head, visiting 1 to CAPACITY slots with
// one read of both RAMs per cycle; a delete that finds its key then relinks the
// neighbours and puts the slot on the front of the free chain. Misses on an empty
// list and inserts into a full list go straight to the result. The link RAM needs
// no clearing pass after reset: a fill mark stands in for the initial free chain.
// The output register holds a finished result, so the next item is accepted
// while that result still waits to be taken.
`include "array_linked_list_with_free_list_core_assert.svh"

module array_linked_list_with_free_list_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [alfl_pkg::OP_W-1:0]     operation_i,
  input  logic [alfl_pkg::KEY_W-1:0]    search_key_i,
  input  logic [alfl_pkg::HANDLE_W-1:0] entry_handle_i,
  input  logic [alfl_pkg::KIND_W-1:0]   entry_kind_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [alfl_pkg::STATUS_W-1:0] status_o,
  output logic [alfl_pkg::SLOT_W-1:0]   slot_index_o,
  output logic [alfl_pkg::HANDLE_W-1:0] found_handle_o,
  output logic [alfl_pkg::KIND_W-1:0]   found_kind_o,
  output logic [alfl_pkg::COUNT_W-1:0]  entry_count_o
);

  import alfl_pkg::*;

  link_req_t link_req;
  link_t     link_rdata;
  pay_req_t  pay_req;
  pay_t      pay_rdata;
  stat_t     stat;

  alfl_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .search_key_i   (search_key_i),
    .entry_handle_i (entry_handle_i),
    .entry_kind_i   (entry_kind_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .slot_index_o   (slot_index_o),
    .found_handle_o (found_handle_o),
    .found_kind_o   (found_kind_o),
    .entry_count_o  (entry_count_o),
    .link_req_o     (link_req),
    .link_rdata_i   (link_rdata),
    .pay_req_o      (pay_req),
    .pay_rdata_i    (pay_rdata),
    .stat_o         (stat)
  );

  alfl_ram #(
    .WIDTH ($bits(link_t)),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_req.we),
    .waddr_i (link_req.waddr),
    .wdata_i (link_req.wdata),
    .wmask_i (link_req.wmask),
    .re_i    (link_req.re),
    .raddr_i (link_req.raddr),
    .rdata_o (link_rdata)
  );

  alfl_ram #(
    .WIDTH ($bits(pay_t)),
    .DEPTH (CAPACITY)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_req.we),
    .waddr_i (pay_req.waddr),
    .wdata_i (pay_req.wdata),
    .wmask_i ({$bits(pay_t){1'b1}}),
    .re_i    (pay_req.re),
    .raddr_i (pay_req.raddr),
    .rdata_o (pay_rdata)
  );

  // head and tail are null together, exactly when the list is empty
  `ALFL_ASSERT_NOW(a_ends_agree, 1'b1, stat.head_nil == stat.tail_nil, "head and tail disagree")
  `ALFL_ASSERT_NOW(a_empty_count, 1'b1, stat.head_nil == (stat.count == '0), "count mismatch")
  `ALFL_ASSERT_NOW(a_count_max, 1'b1, stat.count <= CAP_CNT, "count above capacity")
  // memories are written only while an item is in flight
  `ALFL_ASSERT_NOW(a_write_busy, link_req.we || pay_req.we, stat.busy, "write while idle")
  `ALFL_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, stat.busy, "accept did not start")

endmodule

// ===== rtl/alfl_ram.sv =====
module alfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [WIDTH-1:0] wmask_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // bit write enables, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wmask_i[i]) begin
          mem_q[waddr_i][i] <= wdata_i[i];
        end
      end
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/alfl_ctrl.sv =====
module alfl_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [alfl_pkg::OP_W-1:0]        operation_i,
  input  logic [alfl_pkg::KEY_W-1:0]       search_key_i,
  input  logic [alfl_pkg::HANDLE_W-1:0]    entry_handle_i,
  input  logic [alfl_pkg::KIND_W-1:0]      entry_kind_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [alfl_pkg::STATUS_W-1:0]    status_o,
  output logic [alfl_pkg::SLOT_W-1:0]      slot_index_o,
  output logic [alfl_pkg::HANDLE_W-1:0]    found_handle_o,
  output logic [alfl_pkg::KIND_W-1:0]      found_kind_o,
  output logic [alfl_pkg::COUNT_W-1:0]     entry_count_o,
  output alfl_pkg::link_req_t              link_req_o,
  input  alfl_pkg::link_t                  link_rdata_i,
  output alfl_pkg::pay_req_t               pay_req_o,
  input  alfl_pkg::pay_t                   pay_rdata_i,
  output alfl_pkg::stat_t                  stat_o
);

  import alfl_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_INS_LINK = 8'b0000_0010,
    S_INS_TAIL = 8'b0000_0100,
    S_WALK     = 8'b0000_1000,
    S_DEL_P    = 8'b0001_0000,
    S_DEL_N    = 8'b0010_0000,
    S_DEL_S    = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  ptr_t head_q, head_d;
  ptr_t tail_q, tail_d;
  ptr_t free_q, free_d;
  ptr_t fill_q, fill_d;
  ptr_t count_q, count_d;
  logic out_valid_q, out_valid_d;

  logic [OP_W-1:0]     op_q, op_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic [KIND_W-1:0]   kind_q, kind_d;
  ptr_t                cur_q, cur_d;
  ptr_t                step_q, step_d;
  ptr_t                p_q, p_d;
  ptr_t                n_q, n_d;
  logic                wr_p_q, wr_p_d;
  logic                wr_n_q, wr_n_d;

  status_e             res_status_q, res_status_d;
  ptr_t                res_slot_q, res_slot_d;
  logic [HANDLE_W-1:0] res_handle_q, res_handle_d;
  logic [KIND_W-1:0]   res_kind_q, res_kind_d;

  status_e             out_status_q, out_status_d;
  ptr_t                out_slot_q, out_slot_d;
  logic [HANDLE_W-1:0] out_handle_q, out_handle_d;
  logic [KIND_W-1:0]   out_kind_q, out_kind_d;
  ptr_t                out_count_q, out_count_d;

  logic can_load;
  ptr_t new_head, new_tail;

  assign can_load = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    free_d       = free_q;
    fill_d       = fill_q;
    count_d      = count_q;
    op_d         = op_q;
    key_d        = key_q;
    handle_d     = handle_q;
    kind_d       = kind_q;
    cur_d        = cur_q;
    step_d       = step_q;
    p_d          = p_q;
    n_d          = n_q;
    wr_p_d       = wr_p_q;
    wr_n_d       = wr_n_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_handle_d = res_handle_q;
    res_kind_d   = res_kind_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_handle_d = out_handle_q;
    out_kind_d   = out_kind_q;
    out_count_d  = out_count_q;
    out_valid_d  = out_valid_q && out_stall_i;
    new_head     = head_q;
    new_tail     = tail_q;
    link_req_o   = '0;
    pay_req_o    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = operation_i;
          key_d        = search_key_i;
          handle_d     = entry_handle_i;
          kind_d       = entry_kind_i;
          res_status_d = ST_OK;
          res_slot_d   = '0;
          res_handle_d = '0;
          res_kind_d   = '0;
          step_d       = ptr_t'(1);
          if (operation_i == OP_INSERT) begin
            if (count_q >= CAP_CNT || free_q >= NIL) begin
              res_status_d = ST_FULL;
              state_d      = S_DONE;
            end else begin
              // fetch the free slot's link in case it came off the free chain
              link_req_o.re    = 1'b1;
              link_req_o.raddr = free_q[IDX_W-1:0];
              cur_d            = free_q;
              state_d          = S_INS_LINK;
            end
          end else if (head_q >= NIL) begin
            res_status_d = ST_NOT_FOUND;
            state_d      = S_DONE;
          end else begin
            link_req_o.re    = 1'b1;
            link_req_o.raddr = head_q[IDX_W-1:0];
            pay_req_o.re     = 1'b1;
            pay_req_o.raddr  = head_q[IDX_W-1:0];
            cur_d            = head_q;
            state_d          = S_WALK;
          end
        end
      end

      S_INS_LINK: begin
        link_req_o.we         = 1'b1;
        link_req_o.waddr      = cur_q[IDX_W-1:0];
        link_req_o.wdata.next = NIL;
        link_req_o.wdata.prev = tail_q;
        link_req_o.wmask      = '1;
        pay_req_o.we          = 1'b1;
        pay_req_o.waddr       = cur_q[IDX_W-1:0];
        pay_req_o.wdata       = '{key: key_q, handle: handle_q, kind: kind_q};
        // slots at or above the fill mark were never linked: they chain in order
        if (cur_q == fill_q) begin
          free_d = cur_q + ptr_t'(1);
          fill_d = fill_q + ptr_t'(1);
        end else begin
          free_d = link_rdata_i.next;
        end
        count_d    = count_q + ptr_t'(1);
        res_slot_d = cur_q;
        if (tail_q < NIL) begin
          state_d = S_INS_TAIL;
        end else begin
          head_d  = cur_q;
          tail_d  = cur_q;
          state_d = S_DONE;
        end
      end

      S_INS_TAIL: begin
        link_req_o.we         = 1'b1;
        link_req_o.waddr      = tail_q[IDX_W-1:0];
        link_req_o.wdata.next = cur_q;
        link_req_o.wmask.next = '1;
        tail_d                = cur_q;
        state_d               = S_DONE;
      end

      S_WALK: begin
        if (pay_rdata_i.key == key_q) begin
          res_slot_d = cur_q;
          if (op_q == OP_DELETE) begin
            p_d      = link_rdata_i.prev;
            n_d      = link_rdata_i.next;
            wr_p_d   = (link_rdata_i.prev < NIL) && (cur_q != head_q);
            wr_n_d   = (link_rdata_i.next < NIL) && (cur_q != tail_q);
            new_head = wr_p_d ? head_q : link_rdata_i.next;
            new_tail = wr_n_d ? tail_q : link_rdata_i.prev;
            if (new_head >= NIL || new_tail >= NIL) begin
              head_d = NIL;
              tail_d = NIL;
            end else begin
              head_d = new_head;
              tail_d = new_tail;
            end
            if (count_q != '0) begin
              count_d = count_q - ptr_t'(1);
            end
            state_d = S_DEL_P;
          end else begin
            res_handle_d = pay_rdata_i.handle;
            res_kind_d   = pay_rdata_i.kind;
            state_d      = S_DONE;
          end
        end else if (link_rdata_i.next >= NIL || step_q >= CAP_CNT) begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_DONE;
        end else begin
          link_req_o.re    = 1'b1;
          link_req_o.raddr = link_rdata_i.next[IDX_W-1:0];
          pay_req_o.re     = 1'b1;
          pay_req_o.raddr  = link_rdata_i.next[IDX_W-1:0];
          cur_d            = link_rdata_i.next;
          step_d           = step_q + ptr_t'(1);
        end
      end

      S_DEL_P: begin
        link_req_o.we         = wr_p_q;
        link_req_o.waddr      = p_q[IDX_W-1:0];
        link_req_o.wdata.next = n_q;
        link_req_o.wmask.next = '1;
        state_d               = S_DEL_N;
      end

      S_DEL_N: begin
        link_req_o.we         = wr_n_q;
        link_req_o.waddr      = n_q[IDX_W-1:0];
        link_req_o.wdata.prev = p_q;
        link_req_o.wmask.prev = '1;
        state_d               = S_DEL_S;
      end

      S_DEL_S: begin
        // freed slot goes on the front of the free chain
        link_req_o.we         = 1'b1;
        link_req_o.waddr      = cur_q[IDX_W-1:0];
        link_req_o.wdata.next = free_q;
        link_req_o.wmask.next = '1;
        free_d                = cur_q;
        state_d               = S_DONE;
      end

      S_DONE: begin
        if (can_load) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_handle_d = res_handle_q;
          out_kind_d   = res_kind_q;
          out_count_d  = count_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NIL;
      tail_q      <= NIL;
      free_q      <= '0;
      fill_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_q      <= free_d;
      fill_q      <= fill_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    handle_q     <= handle_d;
    kind_q       <= kind_d;
    cur_q        <= cur_d;
    step_q       <= step_d;
    p_q          <= p_d;
    n_q          <= n_d;
    wr_p_q       <= wr_p_d;
    wr_n_q       <= wr_n_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_handle_q <= res_handle_d;
    res_kind_q   <= res_kind_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_handle_q <= out_handle_d;
    out_kind_q   <= out_kind_d;
    out_count_q  <= out_count_d;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign slot_index_o   = SLOT_W'(out_slot_q);
  assign found_handle_o = out_handle_q;
  assign found_kind_o   = out_kind_q;
  assign entry_count_o  = COUNT_W'(out_count_q);

  assign stat_o.count    = count_q;
  assign stat_o.head_nil = (head_q >= NIL);
  assign stat_o.tail_nil = (tail_q >= NIL);
  assign stat_o.busy     = (state_q != S_IDLE);

endmodule

// ===== tb/tb_array_linked_list_with_free_list_core.sv =====
`timescale 1ns / 1ps

module tb_array_linked_list_with_free_list_core;
  import alfl_pkg::*;

  localparam int unsigned CAP         = alfl_pkg::CAPACITY;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int          POOL_N      = 20;
  localparam int          HOLD_CYCLES = 300;
  localparam int          STALL_LIMIT = 3000;
  localparam int          PHASE_ITEMS = 250;
  localparam int          MAX_REPORTS = 60;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [KIND_W-1:0]   kind;
  } list_cmd_t;

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic [KIND_W-1:0]   kind;
    logic [COUNT_W-1:0]  count;
  } list_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [OP_W-1:0]     operation_i;
  logic [KEY_W-1:0]    search_key_i;
  logic [HANDLE_W-1:0] entry_handle_i;
  logic [KIND_W-1:0]   entry_kind_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [STATUS_W-1:0] status_o;
  logic [SLOT_W-1:0]   slot_index_o;
  logic [HANDLE_W-1:0] found_handle_o;
  logic [KIND_W-1:0]   found_kind_o;
  logic [COUNT_W-1:0]  entry_count_o;

  array_linked_list_with_free_list_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .search_key_i   (search_key_i),
    .entry_handle_i (entry_handle_i),
    .entry_kind_i   (entry_kind_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .slot_index_o   (slot_index_o),
    .found_handle_o (found_handle_o),
    .found_kind_o   (found_kind_o),
    .entry_count_o  (entry_count_o)
  );

  list_cmd_t    cmd_queue[$];
  list_result_t awaited_results[$];
  logic [KEY_W-1:0] key_pool [POOL_N];

  int   fail_count     = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_cnt       = 0;
  int   quiet_cycles   = 0;
  bit   hold_req       = 1'b0;
  logic in_taken       = 1'b0;

  // shadow copy of the list
  logic [KEY_W-1:0]    sh_key    [CAP];
  logic [HANDLE_W-1:0] sh_handle [CAP];
  logic [KIND_W-1:0]   sh_kind   [CAP];
  ptr_t                sh_next   [CAP];
  ptr_t                sh_prev   [CAP];
  ptr_t                sh_head;
  ptr_t                sh_tail;
  ptr_t                sh_free;
  logic [COUNT_W-1:0]  sh_used;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  function automatic void list_reset();
    for (int i = 0; i < CAP; i++) begin
      sh_key[i]    = '0;
      sh_handle[i] = '0;
      sh_kind[i]   = '0;
      sh_prev[i]   = '0;
      sh_next[i]   = ptr_t'(i + 1);
    end
    sh_head = NIL;
    sh_tail = NIL;
    sh_free = '0;
    sh_used = '0;
  endfunction

  function automatic ptr_t list_find(input logic [KEY_W-1:0] k);
    ptr_t cur;
    cur = sh_head;
    for (int steps = 0; steps < CAP && cur < CAP; steps++) begin
      if (sh_key[cur[IDX_W-1:0]] == k) return cur;
      cur = sh_next[cur[IDX_W-1:0]];
    end
    return NIL;
  endfunction

  function automatic list_result_t list_apply(input logic [OP_W-1:0] op,
                                              input logic [KEY_W-1:0] k,
                                              input logic [HANDLE_W-1:0] h,
                                              input logic [KIND_W-1:0] kd);
    list_result_t r;
    ptr_t s;
    ptr_t p;
    ptr_t n;
    r.status = ST_OK;
    r.slot   = '0;
    r.handle = '0;
    r.kind   = '0;
    case (op)
      OP_INSERT: begin
        if (sh_used >= CAP || sh_free >= CAP) begin
          r.status = ST_FULL;
        end else begin
          s = sh_free;
          sh_free = sh_next[s[IDX_W-1:0]];
          sh_key[s[IDX_W-1:0]]    = k;
          sh_handle[s[IDX_W-1:0]] = h;
          sh_kind[s[IDX_W-1:0]]   = kd;
          sh_next[s[IDX_W-1:0]]   = NIL;
          sh_prev[s[IDX_W-1:0]]   = sh_tail;
          if (sh_tail < CAP) sh_next[sh_tail[IDX_W-1:0]] = s;
          else sh_head = s;
          sh_tail = s;
          sh_used = sh_used + 1'b1;
          r.slot = s[SLOT_W-1:0];
        end
      end
      OP_DELETE: begin
        s = list_find(k);
        if (s >= CAP) begin
          r.status = ST_NOT_FOUND;
        end else begin
          p = sh_prev[s[IDX_W-1:0]];
          n = sh_next[s[IDX_W-1:0]];
          if (p < CAP && s != sh_head) sh_next[p[IDX_W-1:0]] = n;
          else sh_head = n;
          if (n < CAP && s != sh_tail) sh_prev[n[IDX_W-1:0]] = p;
          else sh_tail = p;
          if (sh_head >= CAP || sh_tail >= CAP) begin
            sh_head = NIL;
            sh_tail = NIL;
          end else begin
            sh_prev[sh_head[IDX_W-1:0]] = NIL;
            sh_next[sh_tail[IDX_W-1:0]] = NIL;
          end
          sh_next[s[IDX_W-1:0]] = sh_free;
          sh_free = s;
          if (sh_used > 0) sh_used = sh_used - 1'b1;
          r.slot = s[SLOT_W-1:0];
        end
      end
      default: begin
        // lookup, and the spare code behaves the same way
        s = list_find(k);
        if (s >= CAP) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.slot   = s[SLOT_W-1:0];
          r.handle = sh_handle[s[IDX_W-1:0]];
          r.kind   = sh_kind[s[IDX_W-1:0]];
        end
      end
    endcase
    r.count = sh_used;
    return r;
  endfunction

  task automatic push_cmd(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                          input logic [HANDLE_W-1:0] h, input logic [KIND_W-1:0] kd);
    list_cmd_t c;
    c.op     = op;
    c.key    = k;
    c.handle = h;
    c.kind   = kd;
    cmd_queue.push_back(c);
  endtask

  function automatic list_cmd_t rand_cmd(input bit fill_mode);
    list_cmd_t c;
    int r;
    int ins_pct;
    int del_pct;
    ins_pct  = fill_mode ? 65 : 25;
    del_pct  = fill_mode ? 15 : 45;
    r        = $urandom_range(0, 99);
    c.key    = key_pool[$urandom_range(0, POOL_N - 1)];
    c.handle = $urandom;
    c.kind   = KIND_W'($urandom_range(0, 7));
    if (r < ins_pct) begin
      c.op = OP_INSERT;
    end else if (r < ins_pct + del_pct) begin
      c.op = OP_DELETE;
    end else if (r < 94) begin
      c.op = OP_LOOKUP;
    end else if (r < 96) begin
      c.op = OP_SPARE;
    end else begin
      // key that almost surely misses
      c.op  = ($urandom_range(0, 1) == 0) ? OP_DELETE : OP_LOOKUP;
      c.key = $urandom;
    end
    return c;
  endfunction

  task automatic refresh_pool();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_N; i++) key_pool[i] = $urandom;
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h actual %h", $time, fname, want, got);
    end
  endtask

  // sender
  always @(negedge clk_i) begin
    if (in_taken) void'(cmd_queue.pop_front());
    if (in_valid_i && !in_taken) begin
      // stalled beat holds
    end else if (rst_ni && cmd_queue.size() != 0 &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      in_valid_i     <= 1'b1;
      operation_i    <= cmd_queue[0].op;
      search_key_i   <= cmd_queue[0].key;
      entry_handle_i <= cmd_queue[0].handle;
      entry_kind_i   <= cmd_queue[0].kind;
    end else begin
      in_valid_i     <= 1'b0;
      operation_i    <= OP_W'($urandom_range(0, 3));
      search_key_i   <= $urandom;
      entry_handle_i <= $urandom;
      entry_kind_i   <= KIND_W'($urandom_range(0, 7));
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // monitor and predictor; results are checked before the new beat is predicted
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result beat with none pending: status %h slot %h count %h",
                   $time, status_o, slot_index_o, entry_count_o);
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("slot_index", 32'(want.slot), 32'(slot_index_o));
        check_field("found_handle", want.handle, found_handle_o);
        check_field("found_kind", 32'(want.kind), 32'(found_kind_o));
        check_field("entry_count", 32'(want.count), 32'(entry_count_o));
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o)
      awaited_results.push_back(list_apply(operation_i, search_key_i,
                                           entry_handle_i, entry_kind_i));
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    bit fill_mode;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    out_stall_i    = 1'b0;
    operation_i    = '0;
    search_key_i   = '0;
    entry_handle_i = '0;
    entry_kind_i   = '0;
    list_reset();
    refresh_pool();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty list misses, then delete of the only entry
    push_cmd(OP_LOOKUP, 32'd5, '0, '0);
    push_cmd(OP_DELETE, 32'd5, '0, '0);
    push_cmd(OP_INSERT, '0, '0, '0);
    push_cmd(OP_DELETE, '0, '0, '0);
    push_cmd(OP_LOOKUP, '0, '0, '0);
    // field extremes and duplicate keys, nearest the head wins
    push_cmd(OP_INSERT, '1, '1, 3'd7);
    push_cmd(OP_INSERT, 32'd1, 32'h5a5a_a5a5, 3'd5);
    push_cmd(OP_INSERT, '1, 32'h1234_5678, 3'd6);
    push_cmd(OP_SPARE, '1, '0, '0);
    push_cmd(OP_DELETE, '1, '0, '0);
    push_cmd(OP_DELETE, '1, '0, '0);
    // fill up, then one insert too many
    for (int i = 0; i < CAP - 1; i++)
      push_cmd(OP_INSERT, 32'd100 + i, $urandom, KIND_W'(i % 8));
    push_cmd(OP_INSERT, 32'd200, $urandom, 3'd2);
    push_cmd(OP_DELETE, 32'd107, '0, '0);
    push_cmd(OP_LOOKUP, 32'd114, '0, '0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      refresh_pool();
      // long receiver hold-off while the sender keeps offering beats
      if (ph == 0) hold_req = 1'b1;
      fill_mode = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) fill_mode = ($urandom_range(0, 2) != 0) ? ~fill_mode : fill_mode;
        cmd_queue.push_back(rand_cmd(fill_mode));
        // sender pauses mid-phase until every result is back
        if (n == PHASE_ITEMS / 2) wait_drained();
      end
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
